### rtl/core/heq_pkg.sv
// ============================================================================
// heq_pkg
// Shared types and constants for the histogram equalizer: command and result
// words, back-end state encoding and default sizes.
// ============================================================================
package heq_pkg;

    // Default sizes handed to the top level parameters
    localparam int COUNT_BITS_DEF = 22;
    localparam int LEVELS_DEF     = 256;

    // Pixel format: 8-bit grayscale, full-scale value 255
    localparam int                    PIX_BITS = 8;
    localparam logic [PIX_BITS-1:0]   PIX_MAX  = '1;

    // Depth of the command and result queues
    localparam int QUEUE_DEPTH = 2;

    // Command classes decoded by the front end
    typedef enum logic {
        CMD_COUNT = 1'b0,
        CMD_MAP   = 1'b1
    } cmd_kind_t;

    // Command word from front end to back end
    typedef struct packed {
        cmd_kind_t           kind;
        logic [PIX_BITS-1:0] pixel;
        logic                last;
        logic                build;   // last pixel of a count pass
        logic                clear;   // last pixel of a map pass
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [PIX_BITS-1:0] mapped;
        logic                last;
    } res_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_MAP_PUSH,
        ST_BLD_RD,
        ST_BLD_ACC,
        ST_BLD_DIV,
        ST_BLD_WAIT,
        ST_BLD_WR
    } back_state_t;

endpackage

### rtl/core/heq_fifo.sv
// ============================================================================
// heq_fifo
// Small synchronous queue with full/empty flags; a push while full and a pop
// while empty are ignored.
// ============================================================================
module heq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/heq_front.sv
// ============================================================================
// heq_front
// Input side: accepts pixel words, classifies them into count or map
// commands and queues them for the back end.
// ============================================================================
module heq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         operation,
    input  logic [heq_pkg::PIX_BITS-1:0] pixel,
    input  logic                         last,
    output logic                         cmd_valid,
    input  logic                         cmd_pop,
    output heq_pkg::cmd_t                cmd
);

    import heq_pkg::*;

    cmd_t                cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;
    logic                cmd_empty;

    // Decode the incoming word into a command
    always_comb
    begin
        cmd_in.kind  = operation ? CMD_MAP : CMD_COUNT;
        cmd_in.pixel = pixel;
        cmd_in.last  = last;
        cmd_in.build = !operation && last;
        cmd_in.clear = operation && last;
    end

    heq_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

### rtl/core/heq_div.sv
// ============================================================================
// heq_div
// Restoring divider producing a Q_W-bit quotient, one bit per cycle. The
// quotient is exact when num < den * 2^Q_W; callers clamp otherwise.
// ============================================================================
module heq_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 22,
    parameter int Q_W   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    localparam int SH_W   = DEN_W + Q_W;
    localparam int STEP_W = (Q_W > 1) ? $clog2(Q_W) : 1;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [SH_W-1:0]   dsh_reg, dsh_next;
    logic [Q_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  dsh_ext;
    logic              fits;

    assign dsh_ext = NUM_W'(dsh_reg);
    assign fits    = (rem_reg >= dsh_ext);

    // Load on start, then test and subtract one shifted divisor per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = SH_W'(den) << (Q_W - 1);
            quot_next = '0;
            step_next = STEP_W'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_ext;
            end
            quot_next = {quot_reg[Q_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

### rtl/core/heq_back.sv
// ============================================================================
// heq_back
// Execution side: histogram and lookup-table memories, count and map
// sequencing, and the table build sweep with its divider.
// ============================================================================
module heq_back #(
    parameter int COUNT_BITS = heq_pkg::COUNT_BITS_DEF,
    parameter int LEVELS     = heq_pkg::LEVELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  heq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output heq_pkg::res_t res
);

    import heq_pkg::*;

    localparam int LVL_BITS = $clog2(LEVELS);
    localparam int CUM_W    = COUNT_BITS + LVL_BITS;
    localparam int NUM_W    = CUM_W + PIX_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Memories
    logic [COUNT_BITS-1:0] hist_mem [LEVELS];
    logic [PIX_BITS-1:0]   lut_mem  [LEVELS];
    logic [COUNT_BITS-1:0] hist_q_reg;
    logic [PIX_BITS-1:0]   lut_q_reg;

    // Control state
    back_state_t           state_reg, state_next;
    logic [LEVELS-1:0]     valid_reg, valid_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [LVL_BITS-1:0]   idx_reg, idx_next;

    // Payload state
    cmd_t                  cmd_reg;
    logic [CUM_W-1:0]      cum_reg, cum_next;
    logic [COUNT_BITS-1:0] base_reg, base_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic                  clamp_reg, clamp_next;

    // Control outputs
    logic                  hist_rd_en;
    logic                  hist_wr_en;
    logic                  lut_rd_en;
    logic                  lut_wr_en;
    logic                  div_start;
    logic [LVL_BITS-1:0]   hist_rd_addr;

    // Datapath
    logic [LVL_BITS-1:0]   cnt_addr;
    logic [LVL_BITS-1:0]   bin_addr;
    logic [COUNT_BITS-1:0] bin_val;
    logic [COUNT_BITS-1:0] bin_inc;
    logic [COUNT_BITS-1:0] total_inc;
    logic [CUM_W-1:0]      cum_sum;
    logic [COUNT_BITS-1:0] base_eff;
    logic [CUM_W-1:0]      diff;
    logic [NUM_W-1:0]      num_prod;
    logic [COUNT_BITS-1:0] den;
    logic                  tiny;
    logic [NUM_W-1:0]      den_sh;
    logic [PIX_BITS-1:0]   quot;
    logic                  div_done;
    logic [PIX_BITS-1:0]   lut_wr_data;

    assign cnt_addr = cmd_reg.pixel[LVL_BITS-1:0];
    assign bin_addr = (state_reg == ST_BLD_ACC) ? idx_reg : cnt_addr;

    // Bin value, treating never-written bins as zero
    assign bin_val   = valid_reg[bin_addr] ? hist_q_reg : '0;
    assign bin_inc   = (bin_val == CNT_MAX) ? bin_val : bin_val + COUNT_BITS'(1);
    assign total_inc = (total_reg == CNT_MAX) ? total_reg : total_reg + COUNT_BITS'(1);

    // Running sum and scaled numerator: (cum - bin0) * 255
    assign cum_sum  = cum_reg + CUM_W'(bin_val);
    assign base_eff = (idx_reg == '0) ? bin_val : base_reg;
    assign diff     = cum_sum - CUM_W'(base_eff);
    assign num_prod = (NUM_W'(diff) << PIX_BITS) - NUM_W'(diff);

    // Divisor is total - 1; a total of 0 or 1 gives an all-zero table
    assign den    = total_reg - COUNT_BITS'(1);
    assign tiny   = (total_reg[COUNT_BITS-1:1] == '0);
    assign den_sh = NUM_W'({den, {PIX_BITS{1'b0}}});

    assign lut_wr_data = tiny ? '0 : (clamp_reg ? PIX_MAX : quot);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == CMD_MAP) ? ST_MAP_PUSH : ST_CNT_WR;
                end
            end
            ST_CNT_WR:
            begin
                state_next = cmd_reg.build ? ST_BLD_RD : ST_IDLE;
            end
            ST_MAP_PUSH:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLD_RD:   state_next = ST_BLD_ACC;
            ST_BLD_ACC:  state_next = ST_BLD_DIV;
            ST_BLD_DIV:  state_next = ST_BLD_WAIT;
            ST_BLD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_BLD_WR;
                end
            end
            ST_BLD_WR:
            begin
                state_next = (idx_reg == LVL_BITS'(LEVELS - 1)) ? ST_IDLE : ST_BLD_RD;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        cmd_pop      = 1'b0;
        hist_rd_en   = 1'b0;
        hist_wr_en   = 1'b0;
        lut_rd_en    = 1'b0;
        lut_wr_en    = 1'b0;
        res_push     = 1'b0;
        div_start    = 1'b0;
        hist_rd_addr = cmd.pixel[LVL_BITS-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop    = cmd_valid;
                hist_rd_en = cmd_valid;
                lut_rd_en  = cmd_valid;
            end
            ST_CNT_WR:   hist_wr_en = 1'b1;
            ST_MAP_PUSH: res_push   = !res_full;
            ST_BLD_RD:
            begin
                hist_rd_en   = 1'b1;
                hist_rd_addr = idx_reg;
            end
            ST_BLD_DIV:  div_start  = 1'b1;
            ST_BLD_WR:   lut_wr_en  = 1'b1;
            default:     ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        valid_next = valid_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        cum_next   = cum_reg;
        base_next  = base_reg;
        num_next   = num_reg;
        clamp_next = clamp_reg;
        unique case (state_reg)
            ST_CNT_WR:
            begin
                total_next           = total_inc;
                valid_next[cnt_addr] = 1'b1;
                idx_next             = '0;
                cum_next             = '0;
            end
            ST_MAP_PUSH:
            begin
                // Drop the histogram after the last pixel of a map pass
                if (!res_full && cmd_reg.clear)
                begin
                    valid_next = '0;
                    total_next = '0;
                end
            end
            ST_BLD_ACC:
            begin
                cum_next  = cum_sum;
                base_next = base_eff;
                num_next  = num_prod;
            end
            ST_BLD_DIV:  clamp_next = (num_reg >= den_sh);
            ST_BLD_WR:   idx_next   = idx_reg + LVL_BITS'(1);
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        cum_reg   <= cum_next;
        base_reg  <= base_next;
        num_reg   <= num_next;
        clamp_reg <= clamp_next;
    end

    // Histogram memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (hist_wr_en)
        begin
            hist_mem[cnt_addr] <= bin_inc;
        end
        if (hist_rd_en)
        begin
            hist_q_reg <= hist_mem[hist_rd_addr];
        end
    end

    // Lookup table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (lut_wr_en)
        begin
            lut_mem[idx_reg] <= lut_wr_data;
        end
        if (lut_rd_en)
        begin
            lut_q_reg <= lut_mem[cmd.pixel[LVL_BITS-1:0]];
        end
    end

    heq_div #(
        .NUM_W (NUM_W),
        .DEN_W (COUNT_BITS),
        .Q_W   (PIX_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den),
        .quot  (quot),
        .done  (div_done)
    );

    assign res.mapped = lut_q_reg;
    assign res.last   = cmd_reg.last;

endmodule

### rtl/core/histogram_equalizer.sv
// Two-pass 8-bit histogram equalizer. Push count-pass pixels (operation 0),
// marking the final one with last; then push map-pass pixels (operation 1),
// each returning one equalized pixel with last copied to last_out. Input and
// output are small queues, so the source and sink stall independently. A
// count pixel reads and rewrites its histogram bin; a map pixel reads the
// table and then waits to push while the result queue is full. After the
// last count pixel the table build steps each gray level through read,
// accumulate, divide, wait and write states, dominated by the 8-step
// bit-serial divider, and input queues up meanwhile. Histogram clearing is
// immediate through per-bin valid bits; no clearing pass runs after reset.
// Mapping before any table has been built returns undefined values.
// ============================================================================
// histogram_equalizer
// Top level: front-end command queue, back-end histogram/table engine and
// result queue.
// ============================================================================
module histogram_equalizer #(
    parameter int COUNT_BITS = heq_pkg::COUNT_BITS_DEF,
    parameter int LEVELS     = heq_pkg::LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         operation,
    input  logic [heq_pkg::PIX_BITS-1:0] pixel,
    input  logic                         last,
    output logic                         empty,
    input  logic                         pop,
    output logic [heq_pkg::PIX_BITS-1:0] mapped_pixel,
    output logic                         last_out
);

    import heq_pkg::*;

    logic                    cmd_valid;
    logic                    cmd_pop;
    cmd_t                    cmd;
    logic                    res_full;
    logic                    res_push;
    res_t                    res;
    logic [$bits(res_t)-1:0] res_bits;
    res_t                    res_out;

    heq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .pixel     (pixel),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    heq_back #(
        .COUNT_BITS (COUNT_BITS),
        .LEVELS     (LEVELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    heq_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_out      = res_t'(res_bits);
    assign mapped_pixel = res_out.mapped;
    assign last_out     = res_out.last;

    // A count command never yields a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == CMD_COUNT) |=> !res_push)
        else $error("result word produced by a count command");

    // Result queue occupancy changes only on a push or a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (!res_push && !(pop && !empty)) |=> $stable(empty) && $stable(res_full))
        else $error("result queue level changed without push or pop");

    // A full command queue stays full until the back end takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_pop) |=> full)
        else $error("command queue drained without a pop");

endmodule

### tb/histogram_equalizer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// histogram_equalizer_tb
// Self-checking bench for the two-pass histogram equalizer. Count passes and
// map passes are pushed through the input queue while a shadow histogram,
// total and lookup table predict every mapped word. Directed cases cover the
// tiny image, the level extremes, partial map passes, recounting into a
// held histogram and a long output stall. Random frames follow, with random
// gaps on both sides and sender pauses.
// ============================================================================
module histogram_equalizer_tb;

    import heq_pkg::*;

    localparam int COUNT_BITS  = COUNT_BITS_DEF;
    localparam int LEVELS      = LEVELS_DEF;
    localparam int ITEM_TARGET = 1300;
    localparam int STALL_LIMIT = 20000;
    // Allow margin at the end for a table build to finish
    localparam int TAIL_CYCLES = 4000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    cmd_kind_t           operation = CMD_COUNT;
    logic [PIX_BITS-1:0] pixel = '0;
    logic                last = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [PIX_BITS-1:0] mapped_pixel;
    logic                last_out;

    // Shadow state of the equalizer
    logic [COUNT_BITS-1:0] bin_count [LEVELS];
    logic [COUNT_BITS-1:0] pixel_total;
    logic [PIX_BITS-1:0]   equal_lut [LEVELS];

    res_t pending_maps[$];

    bit idle_on = 1'b1;
    int sink_hold = 0;
    int errors = 0;
    int stall_cycles = 0;
    int items_sent = 0;
    int pixels_counted = 0;
    int pixels_mapped = 0;
    int tables_built = 0;
    int tiny_tables = 0;

    histogram_equalizer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .pixel        (pixel),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .mapped_pixel (mapped_pixel),
        .last_out     (last_out)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [COUNT_BITS-1:0] sat_add1(logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Rebuild the lookup table from the held histogram
    function automatic void build_equal_lut();
        longint unsigned running;
        longint unsigned offset;
        longint unsigned divisor;
        longint unsigned q;
        running = 0;
        offset  = bin_count[0];
        tables_built++;
        if (pixel_total <= 1)
        begin
            tiny_tables++;
            for (int i = 0; i < LEVELS; i++)
                equal_lut[i] = '0;
            return;
        end
        divisor = pixel_total - 1;
        for (int i = 0; i < LEVELS; i++)
        begin
            running += bin_count[i];
            q = ((running - offset) * longint'(PIX_MAX)) / divisor;
            equal_lut[i] = (q > PIX_MAX) ? PIX_MAX : q[PIX_BITS-1:0];
        end
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < LEVELS; i++)
            bin_count[i] = '0;
        pixel_total = '0;
    endfunction

    // Advance the shadow state by one accepted word
    function automatic void predict_word(cmd_kind_t op, logic [PIX_BITS-1:0] px, logic lst);
        res_t want;
        if (op == CMD_COUNT)
        begin
            bin_count[px] = sat_add1(bin_count[px]);
            pixel_total   = sat_add1(pixel_total);
            pixels_counted++;
            if (lst)
                build_equal_lut();
        end
        else
        begin
            want.mapped = equal_lut[px];
            want.last   = lst;
            pending_maps.push_back(want);
            pixels_mapped++;
            if (lst)
                clear_histogram();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one word at the falling edge and hold it until accepted
    task automatic send_pixel(cmd_kind_t op, logic [PIX_BITS-1:0] px, logic lst);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push      = 1'b1;
        operation = op;
        pixel     = px;
        last      = lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_word(op, px, lst);
        items_sent++;
    endtask

    // Drop push and hold until every mapped word has come back
    task automatic wait_all_mapped();
        @(negedge clk);
        push = 1'b0;
        while (pending_maps.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PIX_BITS-1:0] draw_level(int lo, int span);
        int v;
        v = lo + $urandom_range(0, span);
        return (v > PIX_MAX) ? PIX_MAX : v[PIX_BITS-1:0];
    endfunction

    task automatic count_pass(int n, int lo, int span);
        for (int i = 0; i < n; i++)
            send_pixel(CMD_COUNT, draw_level(lo, span), i == n - 1);
    endtask

    task automatic map_pass(int n, bit with_last);
        for (int i = 0; i < n; i++)
            send_pixel(CMD_MAP, PIX_BITS'($urandom_range(0, PIX_MAX)),
                       with_last && (i == n - 1));
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    // Draw a gap per word; a requested hold-off replaces one gap
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (sink_hold != 0)
            begin
                gap = sink_hold;
                sink_hold = 0;
            end
            repeat (gap)
            begin
                @(negedge clk);
                pop = 1'b0;
            end
            @(negedge clk);
            pop = 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    // Compare each popped word with the oldest expectation
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_maps.size() == 0)
            begin
                $error("unexpected word: mapped_pixel=%0d last_out=%0b",
                       mapped_pixel, last_out);
                errors++;
            end
            else
            begin
                want = pending_maps.pop_front();
                if (mapped_pixel !== want.mapped)
                begin
                    $error("mapped_pixel: expected %0d, got %0d", want.mapped, mapped_pixel);
                    errors++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %0b, got %0b", want.last, last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
                $display("histogram_equalizer_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One counted pixel: every table entry must be zero
    task automatic test_tiny_image();
        send_pixel(CMD_COUNT, 8'd128, 1'b1);
        send_pixel(CMD_MAP, 8'd0, 1'b0);
        send_pixel(CMD_MAP, PIX_MAX, 1'b1);
    endtask

    // Pixels at both ends of the range, level zero counted twice
    task automatic test_level_extremes();
        send_pixel(CMD_COUNT, 8'd0, 1'b0);
        send_pixel(CMD_COUNT, 8'd0, 1'b0);
        send_pixel(CMD_COUNT, PIX_MAX, 1'b0);
        send_pixel(CMD_COUNT, PIX_MAX, 1'b0);
        send_pixel(CMD_COUNT, 8'd128, 1'b0);
        send_pixel(CMD_COUNT, 8'd1, 1'b1);
        send_pixel(CMD_MAP, 8'd0, 1'b0);
        send_pixel(CMD_MAP, 8'd1, 1'b0);
        send_pixel(CMD_MAP, 8'd128, 1'b0);
        send_pixel(CMD_MAP, PIX_MAX, 1'b0);
    endtask

    // Map pass without last keeps the histogram; recount builds on top of it
    task automatic test_partial_map_keeps_counts();
        send_pixel(CMD_MAP, 8'd64, 1'b0);
        send_pixel(CMD_COUNT, PIX_MAX, 1'b1);
        send_pixel(CMD_MAP, 8'd0, 1'b0);
        send_pixel(CMD_MAP, PIX_MAX, 1'b1);
    endtask

    // Two count passes back to back, the second adds to the held histogram
    task automatic test_count_after_build();
        send_pixel(CMD_COUNT, 8'd10, 1'b0);
        send_pixel(CMD_COUNT, 8'd200, 1'b1);
        send_pixel(CMD_COUNT, 8'd10, 1'b1);
        send_pixel(CMD_MAP, 8'd10, 1'b0);
        send_pixel(CMD_MAP, 8'd200, 1'b0);
        send_pixel(CMD_MAP, 8'd9, 1'b1);
    endtask

    // Stall the output long enough to fill both queues
    task automatic test_backpressure();
        idle_on = 1'b0;
        wait_all_mapped();
        sink_hold = HOLD_CYCLES;
        count_pass(16, 0, PIX_MAX);
        map_pass(48, 1'b1);
        wait_all_mapped();
        idle_on = 1'b1;
    endtask

    // Random frames, mostly well formed, with noise and broken passes mixed in
    task automatic test_random_frames();
        int kind;
        int lo;
        int span;
        int n;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 15);
            if ($urandom_range(0, 1))
            begin
                lo   = 0;
                span = PIX_MAX;
            end
            else
            begin
                lo   = $urandom_range(0, PIX_MAX);
                span = $urandom_range(0, 15);
            end
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 250)
                                             : $urandom_range(1, 40);
            if (kind == 0)
            begin
                // noise: random operation and last on every word
                repeat ($urandom_range(1, 12))
                    send_pixel(cmd_kind_t'($urandom_range(0, 1)),
                               PIX_BITS'($urandom_range(0, PIX_MAX)),
                               1'($urandom_range(0, 1)));
            end
            else if (kind == 1)
            begin
                count_pass(n, lo, span);
                map_pass($urandom_range(1, 20), 1'b0);
            end
            else if (kind == 2)
            begin
                count_pass(n, lo, span);
                count_pass($urandom_range(1, 20), lo, span);
                map_pass($urandom_range(1, 40), 1'b1);
            end
            else
            begin
                count_pass(n, lo, span);
                map_pass($urandom_range(1, 40), 1'b1);
            end
            if ($urandom_range(0, 5) == 0)
                wait_all_mapped();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clear_histogram();
        for (int i = 0; i < LEVELS; i++)
            equal_lut[i] = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_tiny_image();
        test_level_extremes();
        test_partial_map_keeps_counts();
        test_count_after_build();
        test_backpressure();
        test_random_frames();

        // Drain, then let a possible table build finish
        wait_all_mapped();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("covered %0d words: %0d counted, %0d mapped, %0d tables built (%0d tiny)",
                 items_sent, pixels_counted, pixels_mapped, tables_built, tiny_tables);
        if (errors == 0)
            $display("histogram_equalizer_tb: done, clean");
        else
            $display("histogram_equalizer_tb: done, errors");
        $finish;
    end

endmodule

### histogram_equalizer.f
rtl/core/heq_pkg.sv
rtl/core/heq_fifo.sv
rtl/core/heq_front.sv
rtl/core/heq_div.sv
rtl/core/heq_back.sv
rtl/core/histogram_equalizer.sv
tb/histogram_equalizer_tb.sv
